### rtl/pcs_pkg.sv
`default_nettype none

package pcs_pkg;

  localparam int unsigned MAX_SLOTS = 4096;
  localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = SLOT_W + 1;
  localparam int unsigned ENT_W     = 12;
  localparam int unsigned ENT_DEPTH = 1 << ENT_W;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned OCC_W     = 13;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_GET    = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ENT_W-1:0]   entity_id;
    logic [VALUE_W-1:0] component_in;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] component_out;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  // slot -> value
  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic [SLOT_W-1:0]  raddr;
  } val_port_t;

  // entity -> slot
  typedef struct packed {
    logic              we;
    logic [ENT_W-1:0]  waddr;
    logic [SLOT_W-1:0] wdata;
    logic [ENT_W-1:0]  raddr;
  } eslot_port_t;

  // slot -> owning entity
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
  } owner_port_t;

  // entity -> presence bit
  typedef struct packed {
    logic             we;
    logic [ENT_W-1:0] waddr;
    logic             wdata;
    logic [ENT_W-1:0] raddr;
  } pres_port_t;

endpackage

`default_nettype wire

### rtl/pcs_ram.sv
`default_nettype none

module pcs_ram #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/pcs_ctrl.sv
`default_nettype none

module pcs_ctrl import pcs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire req_t              in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rsp_t                   out_data_o,
  output val_port_t              val_port_o,
  input  wire logic [VALUE_W-1:0] val_rdata_i,
  output eslot_port_t            eslot_port_o,
  input  wire logic [SLOT_W-1:0] eslot_rdata_i,
  output owner_port_t            owner_port_o,
  input  wire logic [ENT_W-1:0]  owner_rdata_i,
  output pres_port_t             pres_port_o,
  input  wire logic              pres_rdata_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_GETRD = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SLOTS);

  logic [2:0]       state_q, state_d;
  logic [ENT_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [CNT_W-1:0] count_q, count_d;
  req_t             req_q, req_d;
  rsp_t             res_q, res_d;
  rsp_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [SLOT_W-1:0] last_slot;
  logic [SLOT_W-1:0] free_slot;
  logic              full;
  logic              out_free;
  logic              rsp_fire;
  rsp_t              rsp_new;

  assign last_slot  = count_q[SLOT_W-1:0] - SLOT_W'(1);
  assign free_slot  = count_q[SLOT_W-1:0];
  assign full       = (count_q == FULL_CNT);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    count_d     = count_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rsp_fire    = 1'b0;
    rsp_new     = res_q;

    // presence and slot reads launch from the incoming word; get launches its value read in EVAL
    val_port_o.we      = 1'b0;
    val_port_o.waddr   = free_slot;
    val_port_o.wdata   = req_q.component_in;
    val_port_o.raddr   = (state_q == S_EVAL) ? eslot_rdata_i : last_slot;
    eslot_port_o.we    = 1'b0;
    eslot_port_o.waddr = req_q.entity_id;
    eslot_port_o.wdata = free_slot;
    eslot_port_o.raddr = in_data_i.entity_id;
    owner_port_o.we    = 1'b0;
    owner_port_o.waddr = free_slot;
    owner_port_o.wdata = req_q.entity_id;
    owner_port_o.raddr = last_slot;
    pres_port_o.we     = 1'b0;
    pres_port_o.waddr  = req_q.entity_id;
    pres_port_o.wdata  = 1'b0;
    pres_port_o.raddr  = in_data_i.entity_id;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        pres_port_o.we    = 1'b1;
        pres_port_o.waddr = clr_cnt_q;
        pres_port_o.wdata = 1'b0;
        clr_cnt_d         = clr_cnt_q + ENT_W'(1);
        if (clr_cnt_q == {ENT_W{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        rsp_fire              = 1'b1;
        rsp_new.component_out = '0;
        rsp_new.status        = ST_ABSENT;
        case (req_q.req_type)
          REQ_ADD: begin
            if (pres_rdata_i) begin
              rsp_new.status = ST_DUP;
            end else if (full) begin
              rsp_new.status = ST_FULL;
            end else begin
              rsp_new.status  = ST_OK;
              val_port_o.we   = 1'b1;
              eslot_port_o.we = 1'b1;
              owner_port_o.we = 1'b1;
              pres_port_o.we  = 1'b1;
              pres_port_o.wdata = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
          REQ_REMOVE: begin
            if (pres_rdata_i && (count_q != '0)) begin
              // move the last slot into the freed one and relink its owner
              rsp_new.status     = ST_OK;
              val_port_o.we      = 1'b1;
              val_port_o.waddr   = eslot_rdata_i;
              val_port_o.wdata   = val_rdata_i;
              owner_port_o.we    = 1'b1;
              owner_port_o.waddr = eslot_rdata_i;
              owner_port_o.wdata = owner_rdata_i;
              eslot_port_o.we    = 1'b1;
              eslot_port_o.waddr = owner_rdata_i;
              eslot_port_o.wdata = eslot_rdata_i;
              pres_port_o.we     = 1'b1;
              count_d = count_q - CNT_W'(1);
            end
          end
          REQ_GET: begin
            if (pres_rdata_i) begin
              rsp_fire = 1'b0;
              state_d  = S_GETRD;
            end
          end
          default: begin
            rsp_new.status = ST_ABSENT;
          end
        endcase
        rsp_new.occupancy = OCC_W'(count_d);
      end
      S_GETRD: begin
        rsp_fire              = 1'b1;
        rsp_new.component_out = val_rdata_i;
        rsp_new.status        = ST_OK;
        rsp_new.occupancy     = OCC_W'(count_q);
      end
      S_DONE: begin
        rsp_fire = 1'b1;
        rsp_new  = res_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (rsp_fire) begin
      if (out_free) begin
        out_d       = rsp_new;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        // hold the result until the output register drains
        res_d   = rsp_new;
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("slot count exceeds table size");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EVAL)
    else $error("accepted word did not enter evaluation");

  a_count_only_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> $past(state_q) == S_EVAL)
    else $error("slot count changed outside evaluation");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> out_valid_q)
    else $error("result parked while output register empty");

endmodule

`default_nettype wire

### rtl/packed_component_store.sv
// Channel  Handshake                 Word
// in       in_valid_i / in_ready_o   in_data_i  (req_type, entity_id, component_in)
// out      out_valid_o / out_ready_i out_data_o (component_out, status, occupancy)
//
// One request at a time: add, remove and every refused request pass IDLE and
// EVAL before the output register; a get of a present entity also passes GETRD
// (the slot value is read only after the entity's slot index comes out of its
// memory). The steps follow from the registered reads of the four memories.
// After reset a clearing pass zeroes every entry of the presence memory;
// in_ready_o stays low until it ends.
// A finished result waits in the output register; if it is still full, the
// next result parks one stage back and the input stalls until it drains.
`default_nettype none

module packed_component_store import pcs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);

  val_port_t         val_port;
  eslot_port_t       eslot_port;
  owner_port_t       owner_port;
  pres_port_t        pres_port;
  logic [VALUE_W-1:0] val_rdata;
  logic [SLOT_W-1:0]  eslot_rdata;
  logic [ENT_W-1:0]   owner_rdata;
  logic               pres_rdata;

  pcs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .val_port_o   (val_port),
    .val_rdata_i  (val_rdata),
    .eslot_port_o (eslot_port),
    .eslot_rdata_i(eslot_rdata),
    .owner_port_o (owner_port),
    .owner_rdata_i(owner_rdata),
    .pres_port_o  (pres_port),
    .pres_rdata_i (pres_rdata)
  );

  pcs_ram #(.DW(VALUE_W), .DEPTH(MAX_SLOTS)) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_port.we),
    .waddr_i(val_port.waddr),
    .wdata_i(val_port.wdata),
    .raddr_i(val_port.raddr),
    .rdata_o(val_rdata)
  );

  pcs_ram #(.DW(SLOT_W), .DEPTH(ENT_DEPTH)) u_eslot_ram (
    .clk_i  (clk_i),
    .we_i   (eslot_port.we),
    .waddr_i(eslot_port.waddr),
    .wdata_i(eslot_port.wdata),
    .raddr_i(eslot_port.raddr),
    .rdata_o(eslot_rdata)
  );

  pcs_ram #(.DW(ENT_W), .DEPTH(MAX_SLOTS)) u_owner_ram (
    .clk_i  (clk_i),
    .we_i   (owner_port.we),
    .waddr_i(owner_port.waddr),
    .wdata_i(owner_port.wdata),
    .raddr_i(owner_port.raddr),
    .rdata_o(owner_rdata)
  );

  pcs_ram #(.DW(1), .DEPTH(ENT_DEPTH)) u_pres_ram (
    .clk_i  (clk_i),
    .we_i   (pres_port.we),
    .waddr_i(pres_port.waddr),
    .wdata_i(pres_port.wdata),
    .raddr_i(pres_port.raddr),
    .rdata_o(pres_rdata)
  );

endmodule

`default_nettype wire

### bench/store_checker.sv
`timescale 1ns / 1ps

module store_checker import pcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  req_t in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  rsp_t out_data_i,
  output int   fail_cnt_o,
  output int   pending_o
);

  logic [VALUE_W-1:0] slot_value     [MAX_SLOTS];
  logic [SLOT_W-1:0]  slot_of_entity [ENT_DEPTH];
  logic [ENT_W-1:0]   owner_of_slot  [MAX_SLOTS];
  logic               entity_here    [ENT_DEPTH];
  logic [CNT_W-1:0]   filled;

  rsp_t expected_rsp [$];
  int   fails;

  // Apply one request to the shadow table and return the word it must produce.
  function automatic rsp_t apply_request(input req_t w);
    rsp_t             r;
    logic [ENT_W-1:0] e;
    logic [SLOT_W-1:0] freed;
    logic [SLOT_W-1:0] last;
    logic [ENT_W-1:0] mover;
    e = w.entity_id;
    r.component_out = '0;
    r.status = ST_OK;
    case (w.req_type)
      REQ_ADD: begin
        if (entity_here[e]) begin
          r.status = ST_DUP;
        end else if (filled >= MAX_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          slot_of_entity[e] = filled[SLOT_W-1:0];
          owner_of_slot[filled[SLOT_W-1:0]] = e;
          slot_value[filled[SLOT_W-1:0]] = w.component_in;
          entity_here[e] = 1'b1;
          filled = filled + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (!entity_here[e] || filled == 0) begin
          r.status = ST_ABSENT;
        end else begin
          // move the last slot into the hole, then shrink
          freed = slot_of_entity[e];
          last = SLOT_W'(filled - 1'b1);
          mover = owner_of_slot[last];
          slot_value[freed] = slot_value[last];
          slot_of_entity[mover] = freed;
          owner_of_slot[freed] = mover;
          entity_here[e] = 1'b0;
          filled = filled - 1'b1;
        end
      end
      REQ_GET: begin
        if (!entity_here[e]) begin
          r.status = ST_ABSENT;
        end else begin
          r.component_out = slot_value[slot_of_entity[e]];
        end
      end
      default: r.status = ST_ABSENT;
    endcase
    r.occupancy = OCC_W'(filled);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    logic bad;
    if (!rst_ni) begin
      for (int i = 0; i < ENT_DEPTH; i++) entity_here[i] = 1'b0;
      filled = '0;
      expected_rsp.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_data_i);
          fails++;
        end else begin
          want = expected_rsp.pop_front();
          bad = 1'b0;
          if (out_data_i.component_out !== want.component_out) begin
            $display("%0t: component_out expected %h actual %h", $time,
                     want.component_out, out_data_i.component_out);
            bad = 1'b1;
          end
          if (out_data_i.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data_i.status);
            bad = 1'b1;
          end
          if (out_data_i.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time,
                     want.occupancy, out_data_i.occupancy);
            bad = 1'b1;
          end
          if (bad) fails++;
        end
      end
      if (in_valid_i && in_ready_i) expected_rsp.push_back(apply_request(in_data_i));
      fail_cnt_o <= fails;
      pending_o <= expected_rsp.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pcs_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE = 16;
  localparam int LIMIT = 1_000_000;
  localparam int FILL_N = 320;
  localparam int PHASES = 8;
  localparam int PHASE_LEN = 110;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  int fail_cnt;
  int pending;
  int cycles = 0;

  int burst_left = 0;
  int gap_max = 0;
  int burst_max = 1;
  int rx_pct = 100;
  int rx_run = 1;
  int rx_left;

  int fill_order [ENT_DEPTH];

  packed_component_store dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  store_checker u_store_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: hold ready at a random level for a random run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_left <= 0;
    end else if (rx_left == 0) begin
      out_ready_i <= ($urandom_range(0, 99) < rx_pct);
      rx_left <= $urandom_range(1, rx_run);
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [ENT_W-1:0] ent,
                          input logic [VALUE_W-1:0] val);
    req_t w;
    int gap;
    w.req_type = kind;
    w.entity_id = ent;
    w.component_in = val;
    if (burst_left <= 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    burst_left--;
  endtask

  // drop valid and hold off until every expected word has come back
  task automatic wait_idle;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin gap_max = 0; burst_max = 1;  rx_pct = 100; rx_run = 1;  end
      1: begin gap_max = 3; burst_max = 8;  rx_pct = 70;  rx_run = 4;  end
      2: begin gap_max = 8; burst_max = 3;  rx_pct = 50;  rx_run = 12; end
      default: begin gap_max = 2; burst_max = 16; rx_pct = 30; rx_run = 12; end
    endcase
  endtask

  initial begin
    int roll;
    int pool_span;
    int add_pct;
    int j;
    int tmp;
    logic [1:0] kind;
    logic [ENT_W-1:0] pool_base;
    logic [VALUE_W-1:0] val;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, duplicate, swap-remove, last-slot remove
    set_idling(1);
    send_req(REQ_GET,    12'd0,    32'h1234_5678);
    send_req(REQ_REMOVE, 12'hFFF,  32'h0);
    send_req(REQ_UNUSED, 12'd7,    32'hFFFF_FFFF);
    send_req(REQ_ADD,    12'd0,    32'h0);
    send_req(REQ_ADD,    12'hFFF,  32'hFFFF_FFFF);
    send_req(REQ_ADD,    12'd0,    32'hDEAD_BEEF);
    send_req(REQ_GET,    12'd0,    32'h0);
    send_req(REQ_GET,    12'hFFF,  32'h0);
    send_req(REQ_ADD,    12'hAAA,  32'hAAAA_AAAA);
    send_req(REQ_ADD,    12'h555,  32'h5555_5555);
    send_req(REQ_REMOVE, 12'd0,    32'hFFFF_FFFF);
    send_req(REQ_GET,    12'h555,  32'h0);
    send_req(REQ_GET,    12'hFFF,  32'h0);
    send_req(REQ_GET,    12'hAAA,  32'h0);
    send_req(REQ_GET,    12'd0,    32'h0);
    send_req(REQ_REMOVE, 12'hAAA,  32'h0);
    send_req(REQ_REMOVE, 12'hAAA,  32'h0);
    send_req(REQ_UNUSED, 12'hFFF,  32'h0);
    send_req(REQ_REMOVE, 12'hFFF,  32'h0);
    send_req(REQ_REMOVE, 12'h555,  32'h0);
    send_req(REQ_GET,    12'h555,  32'h0);
    wait_idle();

    // fill part of the table in random order, poke it, then empty it again
    for (int i = 0; i < ENT_DEPTH; i++) fill_order[i] = i;
    for (int i = ENT_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    set_idling($urandom_range(0, 1));
    for (int i = 0; i < FILL_N; i++)
      send_req(REQ_ADD, ENT_W'(fill_order[i]), $urandom);
    for (int i = 0; i < 12; i++) begin
      send_req(REQ_GET, ENT_W'($urandom), 32'h0);
      send_req(REQ_ADD, ENT_W'($urandom), $urandom);
    end
    for (int i = FILL_N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    for (int i = 0; i < FILL_N; i++) begin
      send_req(REQ_REMOVE, ENT_W'(fill_order[i]), $urandom);
      if ((i % 64) == 0) send_req(REQ_GET, ENT_W'(fill_order[FILL_N - 1]), 32'h0);
    end
    wait_idle();

    // random phases over mostly small entity pools so most requests hit live entries
    for (int ph = 0; ph < PHASES; ph++) begin
      set_idling(ph == 0 ? 0 : $urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: pool_span = 4;
        1: pool_span = 16;
        2: pool_span = 64;
        default: pool_span = ENT_DEPTH;
      endcase
      pool_base = ENT_W'($urandom);
      add_pct = $urandom_range(30, 50);
      for (int k = 0; k < PHASE_LEN; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_pct) kind = REQ_ADD;
        else if (roll < 72) kind = REQ_REMOVE;
        else if (roll < 96) kind = REQ_GET;
        else kind = REQ_UNUSED;
        roll = $urandom_range(0, 99);
        if (roll < 8) val = '0;
        else if (roll < 16) val = '1;
        else val = $urandom;
        send_req(kind, pool_base + ENT_W'($urandom_range(0, pool_span - 1)), val);
      end
      if ($urandom_range(0, 2) == 0) wait_idle();
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pcs_pkg.sv
rtl/pcs_ram.sv
rtl/pcs_ctrl.sv
rtl/packed_component_store.sv
bench/store_checker.sv
bench/tb_top.sv
